// ===== sv/cht_pkg.sv =====
`timescale 1ns / 1ps
package cht_pkg;

    localparam int KEY_BITS = 32;
    localparam int CFG_BITS = 7;

    localparam logic [1:0] OP_ADD      = 2'd0;
    localparam logic [1:0] OP_REMOVE   = 2'd1;
    localparam logic [1:0] OP_GET      = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_UPDATED   = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_FOUND     = 3'd4;
    localparam logic [2:0] ST_FULL      = 3'd5;

    typedef struct packed {
        logic [1:0]  operation;
        logic signed [31:0] key;
        logic [31:0] new_value;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] read_value;
    } rsp_t;

endpackage

// ===== sv/chained_hash_table_engine.sv =====
`timescale 1ns / 1ps
// Key-value table, separate chaining, bucket = key mod bucket_count (non-negative)
// (a bucket_count of 0 counts as 1, one above MAX_BUCKETS as MAX_BUCKETS).
// A request passes the front divider (one quotient bit per cycle) and then the
// back end, which reads one way of the bucket per cycle from the key/value RAMs
// and then commits. A two-part pipeline: the front divides the next word while
// the back scans, so sustained rate is set by the divider. A held result stops
// the back end, then the front, then the input. After reset the back end runs
// a clearing pass over the valid bits of all MAX_BUCKETS * WAYS_PER_BUCKET slots
// before it takes its first word.
module chained_hash_table_engine #(
    parameter int MAX_BUCKETS = 64,
    parameter int WAYS_PER_BUCKET = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data,
    input  logic          s_valid,
    output logic          s_ready,
    input  cht_pkg::req_t s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output cht_pkg::rsp_t m_data
);
    import cht_pkg::*;

    localparam int BKT_W = $clog2(MAX_BUCKETS) > 0 ? $clog2(MAX_BUCKETS) : 1;

    logic [6:0]       bucket_count_reg;
    logic             q_valid, q_ready;
    req_t             q_req;
    logic [BKT_W-1:0] q_bucket;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bucket_count_reg <= 7'd64;
        end else if (cfg_valid) begin
            bucket_count_reg <= cfg_data;
        end
    end

    cht_front #(.MAX_BUCKETS(MAX_BUCKETS), .BKT_W(BKT_W)) u_front (
        .aclk(aclk), .aresetn(aresetn), .bucket_count(bucket_count_reg),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_bucket(q_bucket));

    cht_back #(.MAX_BUCKETS(MAX_BUCKETS), .WAYS_PER_BUCKET(WAYS_PER_BUCKET),
               .VALUE_BITS(VALUE_BITS), .BKT_W(BKT_W)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req), .q_bucket(q_bucket),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data));
endmodule

// ===== sv/cht_ram.sv =====
`timescale 1ns / 1ps
module cht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== sv/cht_front.sv =====
`timescale 1ns / 1ps
// Bucket = key mod divisor: restoring division, one quotient bit per cycle.
module cht_front #(
    parameter int MAX_BUCKETS = 64,
    parameter int BKT_W = 6
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [6:0]      bucket_count,
    input  logic            s_valid,
    output logic            s_ready,
    input  cht_pkg::req_t   s_data,
    output logic            q_valid,
    input  logic            q_ready,
    output cht_pkg::req_t   q_req,
    output logic [BKT_W-1:0] q_bucket
);
    import cht_pkg::*;

    localparam int CNT_W = 6;

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    req_t               req_reg;
    logic [31:0]        mag_reg;
    logic [12:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [12:0]        div_reg;
    logic [12:0]        div_sat;
    logic [13:0]        shifted;
    logic [12:0]        final_rem;

    always_comb begin
        if (bucket_count == 7'd0) begin
            div_sat = 13'd1;
        end else if (32'(bucket_count) > 32'(MAX_BUCKETS)) begin
            div_sat = 13'(MAX_BUCKETS);
        end else begin
            div_sat = 13'(bucket_count);
        end
    end

    assign s_ready = !busy_reg && !done_reg;
    assign shifted = {rem_reg, mag_reg[31]};

    always_comb begin
        if (shifted >= {1'b0, div_reg}) begin
            rem_next = 13'(shifted - {1'b0, div_reg});
        end else begin
            rem_next = shifted[12:0];
        end
    end

    // negative key: fold nonzero remainder back into range
    always_comb begin
        if (req_reg.key[31] && rem_reg != 13'd0) begin
            final_rem = div_reg - rem_reg;
        end else begin
            final_rem = rem_reg;
        end
    end

    assign busy_next = busy_reg ? (cnt_reg != CNT_W'(31)) : (s_valid && s_ready);
    assign done_next = done_reg ? !q_ready : (busy_reg && cnt_reg == CNT_W'(31));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        if (s_valid && s_ready) begin
            req_reg <= s_data;
            mag_reg <= s_data.key[31] ? 32'(-s_data.key) : s_data.key;
            rem_reg <= 13'd0;
            cnt_reg <= '0;
            div_reg <= div_sat;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            mag_reg <= {mag_reg[30:0], 1'b0};
            cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    assign q_valid  = done_reg;
    assign q_req    = req_reg;
    assign q_bucket = BKT_W'(final_rem);

    assert property (@(posedge aclk) disable iff (!aresetn) !(busy_reg && done_reg))
        else $error("divider busy while holding a result");
    assert property (@(posedge aclk) disable iff (!aresetn) done_reg |-> final_rem < div_reg)
        else $error("bucket out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (done_reg && !q_ready) |=> done_reg && $stable(q_bucket))
        else $error("bucket dropped while stalled");
endmodule

// ===== sv/cht_back.sv =====
`timescale 1ns / 1ps
// Walks a bucket: one RAM read per way, then a write if an add or remove succeeds.
module cht_back #(
    parameter int MAX_BUCKETS = 64,
    parameter int WAYS_PER_BUCKET = 8,
    parameter int VALUE_BITS = 32,
    parameter int BKT_W = 6
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  cht_pkg::req_t    q_req,
    input  logic [BKT_W-1:0] q_bucket,
    output logic             m_valid,
    input  logic             m_ready,
    output cht_pkg::rsp_t    m_data
);
    import cht_pkg::*;

    localparam int SLOTS = MAX_BUCKETS * WAYS_PER_BUCKET;
    localparam int AW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
    localparam int WAY_W = $clog2(WAYS_PER_BUCKET) > 0 ? $clog2(WAYS_PER_BUCKET) : 1;
    localparam int WC_W = $clog2(WAYS_PER_BUCKET + 1) + 1;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DONE  = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [1:0]         state_reg, state_next;
    logic [AW-1:0]      clr_reg;
    req_t               req_reg;
    logic [AW-1:0]      base_reg;
    logic [WC_W-1:0]    way_reg;   // way whose read data is arriving is way_reg-1
    logic               hit_reg, free_reg;
    logic [WAY_W-1:0]   hit_way_reg, free_way_reg;
    logic [VALUE_BITS-1:0] hit_val_reg;
    logic               out_valid_reg;
    rsp_t               out_reg;

    logic [AW-1:0]      raddr, waddr;
    logic [32:0]        kv_rd, kv_wdata;
    logic [31:0]        key_rd;
    logic [VALUE_BITS-1:0] val_rd;
    logic               we_kv, we_val;
    logic [WAY_W-1:0]   cur_way;
    logic               cur_valid;
    logic               commit;

    assign cur_way   = WAY_W'(way_reg - WC_W'(1));
    assign cur_valid = kv_rd[32];
    assign key_rd    = kv_rd[31:0];
    assign raddr     = AW'(base_reg + AW'(way_reg[WAY_W-1:0]));

    // valid bit rides on top of the key
    cht_ram #(.WIDTH(33), .DEPTH(SLOTS)) u_key (
        .aclk(aclk), .we(we_kv), .waddr(waddr), .wdata(kv_wdata),
        .raddr(raddr), .rdata(kv_rd));
    cht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val (
        .aclk(aclk), .we(we_val), .waddr(waddr),
        .wdata(req_reg.new_value[VALUE_BITS-1:0]),
        .raddr(raddr), .rdata(val_rd));

    assign q_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    logic scan_end;
    assign scan_end = (state_reg == S_SCAN) && (way_reg == WC_W'(WAYS_PER_BUCKET));
    assign commit   = (state_reg == S_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        we_kv    = 1'b0;
        we_val   = 1'b0;
        kv_wdata = {1'b0, req_reg.key};
        waddr    = AW'(base_reg + AW'(hit_way_reg));
        if (state_reg == S_CLEAR) begin
            we_kv = 1'b1;
            waddr = clr_reg;
        end else if (commit) begin
            if (req_reg.operation == OP_ADD) begin
                if (hit_reg) begin
                    we_val = 1'b1;
                end else if (free_reg) begin
                    we_kv    = 1'b1;
                    we_val   = 1'b1;
                    kv_wdata = {1'b1, req_reg.key};
                    waddr    = AW'(base_reg + AW'(free_way_reg));
                end
            end else if (req_reg.operation == OP_REMOVE && hit_reg) begin
                we_kv = 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (q_valid) state_next = S_SCAN;
            S_SCAN: if (scan_end) state_next = S_DONE;
            S_DONE: if (commit) state_next = S_IDLE;
            S_CLEAR: if (clr_reg == AW'(SLOTS - 1)) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR) begin
                clr_reg <= clr_reg + AW'(1);
            end
            if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (commit) begin
                out_valid_reg <= 1'b1;
            end
        end
        if (state_reg == S_IDLE && q_valid) begin
            req_reg  <= q_req;
            base_reg <= AW'(AW'(q_bucket) * AW'(WAYS_PER_BUCKET));
            way_reg  <= '0;
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end else if (state_reg == S_SCAN) begin
            if (!scan_end) begin
                way_reg <= way_reg + WC_W'(1);
            end
            if (way_reg != '0) begin
                if (cur_valid && key_rd == req_reg.key && !hit_reg) begin
                    hit_reg     <= 1'b1;
                    hit_way_reg <= cur_way;
                    hit_val_reg <= val_rd;
                end
                if (!cur_valid && !free_reg) begin
                    free_reg     <= 1'b1;
                    free_way_reg <= cur_way;
                end
            end
        end
        if (commit) begin
            out_reg.read_value <= '0;
            case (req_reg.operation)
                OP_ADD: out_reg.status <= hit_reg ? ST_UPDATED
                                        : (free_reg ? ST_INSERTED : ST_FULL);
                OP_REMOVE: out_reg.status <= hit_reg ? ST_REMOVED : ST_NOT_FOUND;
                OP_GET: begin
                    out_reg.status <= hit_reg ? ST_FOUND : ST_NOT_FOUND;
                    if (hit_reg) begin
                        out_reg.read_value <= 32'(hit_val_reg);
                    end
                end
                default: out_reg.status <= ST_NOT_FOUND;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("result dropped while stalled");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result without a finished scan");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (we_kv || we_val) |-> (state_reg == S_DONE || state_reg == S_CLEAR))
        else $error("store written outside commit");
endmodule
